FILE: sv/tid_pkg.sv
// Package for the telnet IAC deframer: parser state and result kind enums,
// telnet command byte codes and the decode result struct. No dependencies.
`timescale 1ns / 1ps

package tid_pkg;

	// Telnet command bytes (RFC 854 and the EOR option)
	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_GA   = 8'd249;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] B_EOR  = 8'd239;

	// Parser position within the byte stream
	typedef enum logic [2:0] {
		ST_NORMAL  = 3'd0,
		ST_IAC     = 3'd1,
		ST_OPT     = 3'd2,
		ST_SUB     = 3'd3,
		ST_SUB_IAC = 3'd4,
		ST_SUB_OPT = 3'd5
	} parse_state_t;

	// Result kinds as seen on the kind port
	typedef enum logic [2:0] {
		K_DATA  = 3'd0,
		K_CMD   = 3'd1,
		K_NEG   = 3'd2,
		K_PAY   = 3'd3,
		K_END   = 3'd4,
		K_ABORT = 3'd5
	} kind_t;

	// One decoded result from the state machine
	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] command_code;
		logic       go_ahead;
	} result_t;

endpackage

FILE: sv/tid_decode.sv
// Combinational next-state and result decode for the telnet IAC parser.
// Depends on tid_pkg for state, kind and command byte definitions.
`timescale 1ns / 1ps

module tid_decode (
	input  tid_pkg::parse_state_t state,
	input  logic [7:0]            verb,
	input  logic [7:0]            in_byte,
	output tid_pkg::parse_state_t next_state,
	output logic                  load_verb,
	output tid_pkg::result_t      result
);

	logic is_verb;

	always_comb begin
		is_verb = (in_byte inside {[tid_pkg::B_WILL:tid_pkg::B_DONT]});
	end

	// Next state and verb capture
	always_comb begin
		next_state = tid_pkg::ST_NORMAL;
		load_verb  = 1'b0;
		case (state)
			tid_pkg::ST_IAC: begin
				if (is_verb) begin
					next_state = tid_pkg::ST_OPT;
					load_verb  = 1'b1;
				end else if (in_byte == tid_pkg::B_SB) begin
					next_state = tid_pkg::ST_SUB;
				end
			end
			tid_pkg::ST_OPT: begin
				next_state = tid_pkg::ST_NORMAL;
			end
			tid_pkg::ST_SUB: begin
				next_state = (in_byte == tid_pkg::B_IAC) ? tid_pkg::ST_SUB_IAC : tid_pkg::ST_SUB;
			end
			tid_pkg::ST_SUB_IAC: begin
				if (is_verb) begin
					next_state = tid_pkg::ST_SUB_OPT;
					load_verb  = 1'b1;
				end else if (in_byte == tid_pkg::B_SE || in_byte == tid_pkg::B_SB) begin
					next_state = tid_pkg::ST_NORMAL;
				end else begin
					next_state = tid_pkg::ST_SUB;
				end
			end
			tid_pkg::ST_SUB_OPT: begin
				next_state = tid_pkg::ST_SUB;
			end
			default: begin
				next_state = (in_byte == tid_pkg::B_IAC) ? tid_pkg::ST_IAC : tid_pkg::ST_NORMAL;
			end
		endcase
	end

	// Result for this byte; unused fields stay zero
	always_comb begin
		result = '{emit: 1'b0, kind: tid_pkg::K_DATA, data_byte: 8'd0,
			command_code: 8'd0, go_ahead: 1'b0};
		case (state)
			tid_pkg::ST_IAC: begin
				if (in_byte == tid_pkg::B_IAC) begin
					result.emit      = 1'b1;
					result.data_byte = in_byte;
				end else if (!is_verb && in_byte != tid_pkg::B_SB
						&& in_byte != tid_pkg::B_SE) begin
					result.emit         = 1'b1;
					result.kind         = tid_pkg::K_CMD;
					result.command_code = in_byte;
					result.go_ahead     = (in_byte == tid_pkg::B_GA)
						|| (in_byte == tid_pkg::B_EOR);
				end
			end
			tid_pkg::ST_OPT, tid_pkg::ST_SUB_OPT: begin
				result.emit         = 1'b1;
				result.kind         = tid_pkg::K_NEG;
				result.data_byte    = in_byte;
				result.command_code = verb;
			end
			tid_pkg::ST_SUB: begin
				if (in_byte != tid_pkg::B_IAC) begin
					result.emit      = 1'b1;
					result.kind      = tid_pkg::K_PAY;
					result.data_byte = in_byte;
				end
			end
			tid_pkg::ST_SUB_IAC: begin
				if (in_byte == tid_pkg::B_IAC) begin
					result.emit      = 1'b1;
					result.kind      = tid_pkg::K_PAY;
					result.data_byte = in_byte;
				end else if (in_byte == tid_pkg::B_SE) begin
					result.emit = 1'b1;
					result.kind = tid_pkg::K_END;
				end else if (in_byte == tid_pkg::B_SB) begin
					result.emit = 1'b1;
					result.kind = tid_pkg::K_ABORT;
				end else if (!is_verb) begin
					result.emit         = 1'b1;
					result.kind         = tid_pkg::K_CMD;
					result.command_code = in_byte;
					result.go_ahead     = (in_byte == tid_pkg::B_GA)
						|| (in_byte == tid_pkg::B_EOR);
				end
			end
			default: begin
				if (in_byte != tid_pkg::B_IAC) begin
					result.emit      = 1'b1;
					result.data_byte = in_byte;
				end
			end
		endcase
	end

endmodule

FILE: sv/telnet_iac_deframer_core.sv
// Telnet IAC deframer: takes one received byte per transfer on the input
// channel and gives at most one result per byte on the output channel (data,
// command, negotiation, subnegotiation payload, end or abort). A byte sits in
// an input register, is decoded against the parser state and lands in the
// result register; a result thus passes the input register and then the
// result register before it can transfer. Sustained rate is one byte per cycle
// while the output side takes results, set by the single state register update
// per byte; bytes that give no result never wait on the output side. The result
// register lets a new byte be taken while a finished result still waits for
// its transfer. Depends on tid_pkg and tid_decode.
`timescale 1ns / 1ps

module telnet_iac_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] command_code,
	output logic       go_ahead
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	tid_pkg::parse_state_t state_q;
	logic [7:0]            verb_q;
	logic                  out_valid_q;
	tid_pkg::result_t      res_q;

	tid_pkg::parse_state_t next_state;
	logic                  load_verb;
	tid_pkg::result_t      res;
	logic                  res_free;
	logic                  advance;

	tid_decode u_decode (
		.state      (state_q),
		.verb       (verb_q),
		.in_byte    (byte_s1),
		.next_state (next_state),
		.load_verb  (load_verb),
		.result     (res)
	);

	// Stage 1 moves on when its result (if any) has somewhere to go
	assign res_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (res_free || !res.emit);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Parser state and pending negotiation verb
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tid_pkg::ST_NORMAL;
			verb_q  <= 8'd0;
		end else if (advance) begin
			state_q <= next_state;
			if (load_verb) begin
				verb_q <= byte_s1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign data_byte    = res_q.data_byte;
	assign command_code = res_q.command_code;
	assign go_ahead     = res_q.go_ahead;

`ifndef NO_ASSERTIONS
	// A stalled byte in stage 1 keeps its value and is not lost
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stage 1 byte lost while stalled");

	// End or abort of a subnegotiation returns the parser to normal
	a_sub_exit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.emit && (res.kind == tid_pkg::K_END || res.kind == tid_pkg::K_ABORT)
		|=> state_q == tid_pkg::ST_NORMAL)
		else $error("parser not back to normal after subnegotiation exit");

	// Negotiation results always carry a WILL/WONT/DO/DONT verb
	a_neg_verb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == tid_pkg::K_NEG
		|-> res_q.command_code >= tid_pkg::B_WILL && res_q.command_code <= tid_pkg::B_DONT)
		else $error("negotiation result without a verb");

	// Go-ahead is flagged only on command results
	a_ga_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.go_ahead |-> res_q.kind == tid_pkg::K_CMD)
		else $error("go-ahead on a non-command result");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for telnet_iac_deframer_core: feeds raw telnet bytes,
// predicts each result with a behavioural IAC parser, or takes a typed row's
// expectation; checks each transfer. Depends on tid_pkg and deframer RTL.
`timescale 1ns / 1ps

module tb_top;

	// One stimulus byte; typed rows carry a hand-written expectation
	typedef struct {
		logic [7:0]     value;
		logic           typed;
		logic           emit;
		tid_pkg::kind_t kind;
		logic [7:0]     data;
		logic [7:0]     cmd;
		logic           ga;
	} row_t;

	localparam int unsigned RANDOM_BYTES = 900;
	localparam int unsigned IDLE_PCT     = 7;
	localparam int unsigned HOLD_CYCLES  = 400;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] kind;
	logic [7:0] data_byte;
	logic [7:0] command_code;
	logic       go_ahead;

	// Directed bytes: extremes, every command class and each special case
	row_t directed_tbl [0:26] = '{
		'{8'h00,           1'b1, 1'b1, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{8'hFE,           1'b1, 1'b1, tid_pkg::K_DATA,  8'hFE, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		// doubled IAC
		'{tid_pkg::B_IAC,  1'b1, 1'b1, tid_pkg::K_DATA,  8'hFF, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_GA,   1'b1, 1'b1, tid_pkg::K_CMD,   8'h00, tid_pkg::B_GA,   1'b1},
		'{tid_pkg::B_IAC,  1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_WILL, 1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{8'h18,           1'b1, 1'b1, tid_pkg::K_NEG,   8'h18, tid_pkg::B_WILL, 1'b0},
		'{tid_pkg::B_IAC,  1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		// stray SE
		'{tid_pkg::B_SE,   1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_SB,   1'b1, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{8'h00,           1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		// payload 255
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_DONT, 1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		// option 255 in subneg
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		// command in subneg
		'{tid_pkg::B_EOR,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_SE,   1'b1, 1'b1, tid_pkg::K_END,   8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_SB,   1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		'{tid_pkg::B_IAC,  1'b0, 1'b0, tid_pkg::K_DATA,  8'h00, 8'h00,           1'b0},
		// nested SB
		'{tid_pkg::B_SB,   1'b1, 1'b1, tid_pkg::K_ABORT, 8'h00, 8'h00,           1'b0}
	};

	row_t                  byte_q [$];
	tid_pkg::result_t      expect_q [$];
	row_t                  cur_row;
	tid_pkg::parse_state_t parser_st;
	logic [7:0]            verb_held;
	int unsigned           total_bytes;
	int unsigned           bytes_taken;
	int unsigned           results_seen;
	int unsigned           errors;
	int unsigned           kind_seen [0:5];

	telnet_iac_deframer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.command_code (command_code),
		.go_ahead     (go_ahead)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic tid_pkg::result_t make_result(input tid_pkg::kind_t k,
			input logic [7:0] d, input logic [7:0] c);
		tid_pkg::result_t r;
		r.emit         = 1'b1;
		r.kind         = k;
		r.data_byte    = d;
		r.command_code = c;
		r.go_ahead     = (k == tid_pkg::K_CMD) && (c == tid_pkg::B_GA || c == tid_pkg::B_EOR);
		return r;
	endfunction

	// Behavioural IAC parser: advances its own state and returns the result, if any
	function automatic tid_pkg::result_t deframe_byte(input logic [7:0] b);
		tid_pkg::result_t r;
		logic             verb;
		r    = '0;
		verb = (b >= tid_pkg::B_WILL) && (b <= tid_pkg::B_DONT);
		case (parser_st)
			tid_pkg::ST_IAC: begin
				if (b == tid_pkg::B_IAC) begin
					parser_st = tid_pkg::ST_NORMAL;
					r = make_result(tid_pkg::K_DATA, b, 8'h00);
				end else if (verb) begin
					verb_held = b;
					parser_st = tid_pkg::ST_OPT;
				end else if (b == tid_pkg::B_SB) begin
					parser_st = tid_pkg::ST_SUB;
				end else begin
					parser_st = tid_pkg::ST_NORMAL;
					if (b != tid_pkg::B_SE)
						r = make_result(tid_pkg::K_CMD, 8'h00, b);
				end
			end
			tid_pkg::ST_OPT: begin
				parser_st = tid_pkg::ST_NORMAL;
				r = make_result(tid_pkg::K_NEG, b, verb_held);
			end
			tid_pkg::ST_SUB: begin
				if (b == tid_pkg::B_IAC)
					parser_st = tid_pkg::ST_SUB_IAC;
				else
					r = make_result(tid_pkg::K_PAY, b, 8'h00);
			end
			tid_pkg::ST_SUB_IAC: begin
				if (b == tid_pkg::B_IAC) begin
					parser_st = tid_pkg::ST_SUB;
					r = make_result(tid_pkg::K_PAY, b, 8'h00);
				end else if (verb) begin
					verb_held = b;
					parser_st = tid_pkg::ST_SUB_OPT;
				end else if (b == tid_pkg::B_SE) begin
					parser_st = tid_pkg::ST_NORMAL;
					r = make_result(tid_pkg::K_END, 8'h00, 8'h00);
				end else if (b == tid_pkg::B_SB) begin
					parser_st = tid_pkg::ST_NORMAL;
					r = make_result(tid_pkg::K_ABORT, 8'h00, 8'h00);
				end else begin
					parser_st = tid_pkg::ST_SUB;
					r = make_result(tid_pkg::K_CMD, 8'h00, b);
				end
			end
			tid_pkg::ST_SUB_OPT: begin
				parser_st = tid_pkg::ST_SUB;
				r = make_result(tid_pkg::K_NEG, b, verb_held);
			end
			default: begin
				if (b == tid_pkg::B_IAC)
					parser_st = tid_pkg::ST_IAC;
				else begin
					parser_st = tid_pkg::ST_NORMAL;
					r = make_result(tid_pkg::K_DATA, b, 8'h00);
				end
			end
		endcase
		return r;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		row_t s;
		s       = '{8'h00, 1'b0, 1'b0, tid_pkg::K_DATA, 8'h00, 8'h00, 1'b0};
		s.value = b;
		byte_q.push_back(s);
	endfunction

	// Mostly well-formed telnet sequences with random content, plus some noise
	function automatic void add_random_sequence();
		int unsigned pick;
		int unsigned n;
		int unsigned r;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			push_byte(8'($urandom_range(0, 254)));
		end else if (pick < 38) begin
			push_byte(tid_pkg::B_IAC);
			push_byte(tid_pkg::B_IAC);
		end else if (pick < 50) begin
			push_byte(tid_pkg::B_IAC);
			push_byte(8'($urandom_range(0, 255)));
		end else if (pick < 62) begin
			push_byte(tid_pkg::B_IAC);
			push_byte(8'($urandom_range(tid_pkg::B_WILL, tid_pkg::B_DONT)));
			push_byte(8'($urandom_range(0, 255)));
		end else if (pick < 65) begin
			push_byte(tid_pkg::B_IAC);
			push_byte(tid_pkg::B_SE);
		end else if (pick < 90) begin
			push_byte(tid_pkg::B_IAC);
			push_byte(tid_pkg::B_SB);
			n = $urandom_range(0, 8);
			for (int unsigned i = 0; i < n; i++) begin
				r = $urandom_range(0, 9);
				if (r < 6)
					push_byte(8'($urandom_range(0, 254)));
				else begin
					push_byte(tid_pkg::B_IAC);
					if (r == 6)
						push_byte(tid_pkg::B_IAC);
					else if (r == 7) begin
						push_byte(8'($urandom_range(tid_pkg::B_WILL, tid_pkg::B_DONT)));
						push_byte(8'($urandom_range(0, 255)));
					end else if (r == 8)
						push_byte(8'($urandom_range(0, tid_pkg::B_GA)));
					else
						push_byte(8'($urandom_range(0, 255)));
				end
			end
			push_byte(tid_pkg::B_IAC);
			push_byte(($urandom_range(0, 99) < 85) ? tid_pkg::B_SE : tid_pkg::B_SB);
		end else begin
			n = $urandom_range(1, 3);
			for (int unsigned i = 0; i < n; i++)
				push_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// Sender: offers bytes from the queue, idling now and then
	initial begin : sender
		row_t nxt;
		in_valid <= 1'b0;
		in_byte  <= 8'h00;
		cur_row  <= '{8'h00, 1'b0, 1'b0, tid_pkg::K_DATA, 8'h00, 8'h00, 1'b0};
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!in_valid || in_ready) begin
				if (byte_q.size() != 0 &&
						((bytes_taken >= 400 && bytes_taken < 550) ||
						$urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = byte_q.pop_front();
					in_valid <= 1'b1;
					in_byte  <= nxt.value;
					cur_row  <= nxt;
				end else
					in_valid <= 1'b0;
			end
			@(posedge clk);
		end
	end

	// Receiver: random stalls, one long hold-off so the block backs up
	initial begin : receiver
		logic held;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held && results_seen >= 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= (results_seen >= 300 && results_seen < 420) ||
					($urandom_range(0, 99) >= IDLE_PCT);
				@(posedge clk);
			end
		end
	end

	// Input transfers: run the parser, queue any expected result
	always @(posedge clk) begin : take_byte
		tid_pkg::result_t r;
		if (arst_n && in_valid && in_ready) begin
			r = deframe_byte(in_byte);
			if (cur_row.typed) begin
				r.emit         = cur_row.emit;
				r.kind         = cur_row.kind;
				r.data_byte    = cur_row.data;
				r.command_code = cur_row.cmd;
				r.go_ahead     = cur_row.ga;
			end
			if (r.emit)
				expect_q.push_back(r);
			bytes_taken++;
		end
	end

	// Output transfers: compare against the oldest expectation
	always @(posedge clk) begin : check_result
		tid_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (kind < 3'd6)
				kind_seen[kind]++;
			if (expect_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got kind %0d data %0d",
					$time, kind, data_byte);
				$display("  cmd %0d ga %0b", command_code, go_ahead);
			end else begin
				want = expect_q.pop_front();
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("data_byte", want.data_byte, data_byte);
				check_field("command_code", want.command_code, command_code);
				check_field("go_ahead", 8'(want.go_ahead), 8'(go_ahead));
			end
		end
	end

	initial begin : watchdog
		#1_000_000;
		$display("tb_top failed");
		$finish;
	end

	// Main sequence: reset, build the stimulus, wait for the drain, report
	initial begin : main_seq
		parser_st    = tid_pkg::ST_NORMAL;
		verb_held    = 8'h00;
		bytes_taken  = 0;
		results_seen = 0;
		errors       = 0;
		for (int i = 0; i < 6; i++)
			kind_seen[i] = 0;
		arst_n <= 1'b0;
		foreach (directed_tbl[i])
			byte_q.push_back(directed_tbl[i]);
		while (byte_q.size() < $size(directed_tbl) + RANDOM_BYTES)
			add_random_sequence();
		total_bytes = byte_q.size();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken < total_bytes)
			@(posedge clk);
		while (expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (expect_q.size() != 0)
			errors++;
		$display("Run covered %0d bytes and %0d results: data %0d, command %0d,",
			bytes_taken, results_seen, kind_seen[0], kind_seen[1]);
		$display("  negotiation %0d, subneg payload %0d, end %0d, abort %0d; %0d errors",
			kind_seen[2], kind_seen[3], kind_seen[4], kind_seen[5], errors);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: files.f
sv/tid_pkg.sv
sv/tid_decode.sv
sv/telnet_iac_deframer_core.sv
tb/tb_top.sv
